[design/fgc_pkg.sv]
package fgc_pkg;

    // Geometry of the flash array. Channel and block counts are powers of two,
    // so a global block number is the channel number over the block index.
    localparam int CHANNELS           = 8;
    localparam int BLOCKS_PER_CHANNEL = 256;
    localparam int PAGES_PER_BLOCK    = 256;
    localparam int TOTAL_BLOCKS       = CHANNELS * BLOCKS_PER_CHANNEL;

    localparam int CH_W   = $clog2(CHANNELS);
    localparam int IDX_W  = $clog2(BLOCKS_PER_CHANNEL);
    localparam int BLK_W  = CH_W + IDX_W;
    localparam int CNT_W  = $clog2(BLOCKS_PER_CHANNEL + 1);
    localparam int VC_W   = $clog2(PAGES_PER_BLOCK + 1);
    localparam int INIT_W = $clog2(TOTAL_BLOCKS);

    // Fixed field widths of the channels and the configuration port.
    localparam int ACT_W     = 3;
    localparam int ID_W      = 11;
    localparam int VP_W      = 9;
    localparam int THR_W     = 12;
    localparam int CFG_IDX_W = 1;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_NOTE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ALLOC   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BUILD   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PICK    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_END     = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 1'b1;

    localparam logic [THR_W-1:0] LOW_THR_RESET  = 12'd204;
    localparam logic [THR_W-1:0] HIGH_THR_RESET = 12'd512;

    // Per-block state word: flags and valid page count.
    typedef struct packed {
        logic            cand;
        logic            free;
        logic [VC_W-1:0] vcnt;
    } meta_t;

    // Victim heap entry: sort key and block index.
    typedef struct packed {
        logic [VC_W-1:0]  key;
        logic [IDX_W-1:0] idx;
    } heap_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_NOTE,
        S_ALLOC_SCAN,
        S_ALLOC_RD,
        S_ALLOC_WR,
        S_REL,
        S_BCLR,
        S_BSCAN_RD,
        S_BSCAN_CHK,
        S_BPOP,
        S_BKEY_RD,
        S_BKEY,
        S_BSH_RD,
        S_BSH_CHK,
        S_PICK_SCAN,
        S_PICK_RD,
        S_END_SCAN,
        S_END_RD,
        S_END_WR,
        S_DONE
    } state_t;

endpackage

[design/fgc_req_if.sv]
interface fgc_req_if;
    logic                       valid;
    logic                       ready;
    logic [fgc_pkg::ACT_W-1:0]  action;
    logic [fgc_pkg::ID_W-1:0]   block_id;
    logic [fgc_pkg::VP_W-1:0]   valid_pages;

    modport source (output valid, action, block_id, valid_pages, input ready);
    modport sink (input valid, action, block_id, valid_pages, output ready);
endinterface

[design/fgc_rsp_if.sv]
interface fgc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [fgc_pkg::ID_W-1:0]   chosen_block;
    logic                       found;
    logic                       should_start;
    logic                       should_stop;
    logic [fgc_pkg::THR_W-1:0]  free_total;

    modport source (output valid, chosen_block, found, should_start, should_stop, free_total,
                    input ready);
    modport sink (input valid, chosen_block, found, should_start, should_stop, free_total,
                  output ready);
endinterface

[design/fgc_ram.sv]
module fgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/flash_gc_block_manager.sv]
// Flash block manager for greedy garbage-collection victim selection.
// Requests arrive on the req channel (action, block_id, valid_pages); each
// accepted request produces exactly one response on the rsp channel with the
// allocated or picked block, a found bit, the free block total and the two
// threshold flags. The thresholds are written through cfg_we/cfg_index/
// cfg_data; the user must do so only while no request is in flight, since
// the block itself does not enforce it. One request is worked on at a time
// by a sequencer around block-sized memories (free FIFOs, candidate FIFOs,
// sorted victim lists, block state). Note and release read the block state
// and update it (a block out of range skips them, and an unused code goes
// straight to the response); allocate scans the channels from the allocation
// pointer for a non-empty free FIFO and pick scans from the victim pointer
// for a heap with entries left. Building a heap walks its channel's blocks,
// then insertion-sorts candidates in up to the threshold difference; ending a
// collection requeues each remaining heap entry as a candidate while there is
// room. After reset the block runs a pass that loads the free FIFOs and
// clears the block state; req.ready stays low until it is done.
// A finished response waits in the output register while rsp.ready is low;
// the next request is still accepted and runs until its own response is due.
module flash_gc_block_manager (
    input  logic                           clk,
    input  logic                           rst_n,
    fgc_req_if.sink                        req,
    fgc_rsp_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [fgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fgc_pkg::THR_W-1:0]      cfg_data
);

    import fgc_pkg::*;

    localparam logic [CNT_W-1:0] BPC_CNT = CNT_W'(BLOCKS_PER_CHANNEL);
    localparam logic [CH_W-1:0]  LAST_CH = CH_W'(CHANNELS - 1);
    localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(BLOCKS_PER_CHANNEL - 1);

    function automatic logic [CH_W-1:0] ch_inc(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] r;
        r = (c == LAST_CH) ? '0 : c + 1'b1;
        return r;
    endfunction

    state_t state_reg, state_next;

    // Request and working registers.
    logic [ACT_W-1:0]  act_reg;
    logic [ID_W-1:0]   bid_reg;
    logic [VP_W-1:0]   vp_reg;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [CH_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [VC_W-1:0]   key_reg, key_next;
    logic [INIT_W-1:0] init_reg;
    logic              found_reg, found_next;
    logic [BLK_W-1:0]  chosen_reg, chosen_next;

    // Global state kept in flip-flops.
    logic [THR_W-1:0] low_thr_reg, high_thr_reg;
    logic [THR_W-1:0] free_count_reg, free_count_next;
    logic [CH_W-1:0]  alloc_ch_reg, alloc_ch_next;
    logic [CH_W-1:0]  victim_ch_reg, victim_ch_next;
    logic [IDX_W-1:0] free_head_reg [CHANNELS];
    logic [IDX_W-1:0] free_head_next [CHANNELS];
    logic [CNT_W-1:0] free_cnt_reg [CHANNELS];
    logic [CNT_W-1:0] free_cnt_next [CHANNELS];
    logic [IDX_W-1:0] cand_head_reg [CHANNELS];
    logic [IDX_W-1:0] cand_head_next [CHANNELS];
    logic [CNT_W-1:0] cand_cnt_reg [CHANNELS];
    logic [CNT_W-1:0] cand_cnt_next [CHANNELS];
    logic [CNT_W-1:0] heap_cnt_reg [CHANNELS];
    logic [CNT_W-1:0] heap_cnt_next [CHANNELS];
    logic [CNT_W-1:0] heap_pos_reg [CHANNELS];
    logic [CNT_W-1:0] heap_pos_next [CHANNELS];

    // Output register.
    logic              out_valid_reg;
    logic [ID_W-1:0]   out_chosen_reg;
    logic              out_found_reg;
    logic              out_start_reg;
    logic              out_stop_reg;
    logic [THR_W-1:0]  out_free_reg;

    // Memory ports.
    logic              free_we, cand_we, heap_we, meta_we;
    logic [BLK_W-1:0]  free_waddr, free_raddr, cand_waddr, cand_raddr;
    logic [BLK_W-1:0]  heap_waddr, heap_raddr, meta_waddr, meta_raddr;
    logic [IDX_W-1:0]  free_wdata, free_rdata, cand_wdata, cand_rdata;
    heap_t             heap_wdata, heap_rdata;
    meta_t             meta_wdata, meta_rdata;

    // Shared conditions, most of them for the current channel.
    logic             req_xfer, out_load;
    logic             free_avail, free_room, cand_room, heap_avail, build_more;
    logic             n_last, ch_last, ix_last;
    logic [THR_W-1:0] thr_diff;
    logic [IDX_W-1:0] free_tail, cand_tail;
    logic [CH_W-1:0]  bid_ch;
    logic [IDX_W-1:0] bid_ix;
    logic [VC_W-1:0]  vp_clamped;

    assign req_xfer   = req.valid && req.ready;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    assign bid_ch     = bid_reg[BLK_W-1:IDX_W];
    assign bid_ix     = bid_reg[IDX_W-1:0];
    assign free_avail = free_cnt_reg[ch_reg] != '0;
    assign free_room  = free_cnt_reg[ch_reg] != BPC_CNT;
    assign cand_room  = cand_cnt_reg[ch_reg] != BPC_CNT;
    assign heap_avail = heap_pos_reg[ch_reg] < heap_cnt_reg[ch_reg];
    assign thr_diff   = high_thr_reg - low_thr_reg;
    assign build_more = (cand_cnt_reg[ch_reg] != '0) && (high_thr_reg > low_thr_reg)
                        && (THR_W'(heap_cnt_reg[ch_reg]) < thr_diff)
                        && (heap_cnt_reg[ch_reg] != BPC_CNT);
    assign n_last     = n_reg == LAST_CH;
    assign ch_last    = ch_reg == LAST_CH;
    assign ix_last    = i_reg == LAST_IX;
    assign free_tail  = free_head_reg[ch_reg] + free_cnt_reg[ch_reg][IDX_W-1:0];
    assign cand_tail  = cand_head_reg[ch_reg] + cand_cnt_reg[ch_reg][IDX_W-1:0];
    assign vp_clamped = (VC_W'(vp_reg) > VC_W'(PAGES_PER_BLOCK)) ? VC_W'(PAGES_PER_BLOCK)
                                                                 : VC_W'(vp_reg);

    assign req.ready = state_reg == S_IDLE;

    // Block state memories.
    fgc_ram #(.WIDTH(IDX_W), .DEPTH(TOTAL_BLOCKS)) u_free_ram (
        .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
        .raddr(free_raddr), .rdata(free_rdata)
    );

    fgc_ram #(.WIDTH(IDX_W), .DEPTH(TOTAL_BLOCKS)) u_cand_ram (
        .clk(clk), .we(cand_we), .waddr(cand_waddr), .wdata(cand_wdata),
        .raddr(cand_raddr), .rdata(cand_rdata)
    );

    fgc_ram #(.WIDTH($bits(heap_t)), .DEPTH(TOTAL_BLOCKS)) u_heap_ram (
        .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .raddr(heap_raddr), .rdata(heap_rdata)
    );

    fgc_ram #(.WIDTH($bits(meta_t)), .DEPTH(TOTAL_BLOCKS)) u_meta_ram (
        .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
        .raddr(meta_raddr), .rdata(meta_rdata)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (init_reg == INIT_W'(TOTAL_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    unique case (req.action)
                        ACT_NOTE:    state_next = S_NOTE;
                        ACT_ALLOC:   state_next = S_ALLOC_SCAN;
                        ACT_RELEASE: state_next = S_REL;
                        ACT_BUILD:   state_next = S_BCLR;
                        ACT_PICK:    state_next = S_PICK_SCAN;
                        ACT_END:     state_next = S_END_SCAN;
                        default:     state_next = S_DONE;
                    endcase
                    if ({1'b0, req.block_id} >= (ID_W + 1)'(TOTAL_BLOCKS)
                        && (req.action == ACT_NOTE || req.action == ACT_RELEASE))
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_NOTE:       state_next = S_DONE;
            S_REL:        state_next = S_DONE;
            S_ALLOC_SCAN:
            begin
                if (free_avail)
                begin
                    state_next = S_ALLOC_RD;
                end
                else if (n_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_ALLOC_RD:   state_next = S_ALLOC_WR;
            S_ALLOC_WR:   state_next = S_DONE;
            S_BCLR:       state_next = S_BSCAN_RD;
            S_BSCAN_RD:   state_next = S_BSCAN_CHK;
            S_BSCAN_CHK:  state_next = ix_last ? S_BPOP : S_BSCAN_RD;
            S_BPOP:
            begin
                if (build_more)
                begin
                    state_next = S_BKEY_RD;
                end
                else
                begin
                    state_next = ch_last ? S_DONE : S_BCLR;
                end
            end
            S_BKEY_RD:    state_next = S_BKEY;
            S_BKEY:       state_next = S_BSH_RD;
            S_BSH_RD:     state_next = (j_reg != '0) ? S_BSH_CHK : S_BPOP;
            S_BSH_CHK:    state_next = (heap_rdata.key > key_reg) ? S_BSH_RD : S_BPOP;
            S_PICK_SCAN:
            begin
                if (heap_avail)
                begin
                    state_next = S_PICK_RD;
                end
                else if (n_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_PICK_RD:    state_next = S_DONE;
            S_END_SCAN:
            begin
                if (heap_avail)
                begin
                    state_next = S_END_RD;
                end
                else if (ch_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_END_RD:     state_next = S_END_WR;
            S_END_WR:     state_next = S_END_SCAN;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls of each sequencer step.
    always_comb
    begin
        ch_next         = ch_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        key_next        = key_reg;
        found_next      = found_reg;
        chosen_next     = chosen_reg;
        free_count_next = free_count_reg;
        alloc_ch_next   = alloc_ch_reg;
        victim_ch_next  = victim_ch_reg;
        free_head_next  = free_head_reg;
        free_cnt_next   = free_cnt_reg;
        cand_head_next  = cand_head_reg;
        cand_cnt_next   = cand_cnt_reg;
        heap_cnt_next   = heap_cnt_reg;
        heap_pos_next   = heap_pos_reg;

        free_we    = 1'b0;
        free_waddr = {ch_reg, free_tail};
        free_wdata = bid_ix;
        free_raddr = {ch_reg, free_head_reg[ch_reg]};
        cand_we    = 1'b0;
        cand_waddr = {ch_reg, cand_tail};
        cand_wdata = i_reg;
        cand_raddr = {ch_reg, cand_head_reg[ch_reg]};
        heap_we    = 1'b0;
        heap_waddr = {ch_reg, j_reg[IDX_W-1:0]};
        heap_wdata = '{key: key_reg, idx: i_reg};
        heap_raddr = {ch_reg, heap_pos_reg[ch_reg][IDX_W-1:0]};
        meta_we    = 1'b0;
        meta_waddr = {ch_reg, i_reg};
        meta_wdata = meta_rdata;
        meta_raddr = {ch_reg, i_reg};

        unique case (state_reg)
            S_INIT:
            begin
                // Load every free FIFO with its blocks and clear block state.
                free_we    = 1'b1;
                free_waddr = BLK_W'(init_reg);
                free_wdata = init_reg[IDX_W-1:0];
                meta_we    = 1'b1;
                meta_waddr = BLK_W'(init_reg);
                meta_wdata = '{cand: 1'b0, free: 1'b1, vcnt: '0};
            end
            S_IDLE:
            begin
                meta_raddr = BLK_W'(req.block_id);
                if (req_xfer)
                begin
                    found_next  = 1'b0;
                    chosen_next = '0;
                    n_next      = '0;
                    unique case (req.action)
                        ACT_ALLOC: ch_next = alloc_ch_reg;
                        ACT_PICK:  ch_next = victim_ch_reg;
                        ACT_BUILD: ch_next = '0;
                        ACT_END:   ch_next = '0;
                        default:   ch_next = req.block_id[BLK_W-1:IDX_W];
                    endcase
                end
            end
            S_NOTE:
            begin
                // Store the valid count; queue unless queued, free or FIFO full.
                meta_we    = 1'b1;
                meta_waddr = BLK_W'(bid_reg);
                meta_wdata = '{cand: meta_rdata.cand, free: meta_rdata.free, vcnt: vp_clamped};
                if (!meta_rdata.cand && !meta_rdata.free && cand_room)
                begin
                    meta_wdata.cand       = 1'b1;
                    cand_we               = 1'b1;
                    cand_wdata            = bid_ix;
                    cand_cnt_next[ch_reg] = cand_cnt_reg[ch_reg] + 1'b1;
                end
            end
            S_REL:
            begin
                // Return a used block to the tail of its channel's free FIFO.
                if (!meta_rdata.free && free_room)
                begin
                    free_we               = 1'b1;
                    free_cnt_next[ch_reg] = free_cnt_reg[ch_reg] + 1'b1;
                    meta_we               = 1'b1;
                    meta_waddr            = BLK_W'(bid_reg);
                    meta_wdata            = '{cand: 1'b0, free: 1'b1, vcnt: '0};
                    free_count_next       = free_count_reg + 1'b1;
                end
            end
            S_ALLOC_SCAN:
            begin
                // Pop the head of the first non-empty free FIFO.
                if (free_avail)
                begin
                    free_head_next[ch_reg] = free_head_reg[ch_reg] + 1'b1;
                    free_cnt_next[ch_reg]  = free_cnt_reg[ch_reg] - 1'b1;
                end
                else
                begin
                    ch_next = ch_inc(ch_reg);
                    n_next  = n_reg + 1'b1;
                end
            end
            S_ALLOC_RD:
            begin
                i_next     = free_rdata;
                meta_raddr = {ch_reg, free_rdata};
            end
            S_ALLOC_WR:
            begin
                meta_we         = 1'b1;
                meta_wdata.free = 1'b0;
                free_count_next = free_count_reg - 1'b1;
                alloc_ch_next   = ch_inc(ch_reg);
                chosen_next     = {ch_reg, i_reg};
                found_next      = 1'b1;
            end
            S_BCLR:
            begin
                heap_cnt_next[ch_reg] = '0;
                heap_pos_next[ch_reg] = '0;
                i_next                = '0;
            end
            S_BSCAN_RD:
            begin
            end
            S_BSCAN_CHK:
            begin
                // Queue used, non-full non-candidate blocks while there is room.
                if (!meta_rdata.cand && !meta_rdata.free
                    && meta_rdata.vcnt < VC_W'(PAGES_PER_BLOCK) && cand_room)
                begin
                    cand_we               = 1'b1;
                    cand_cnt_next[ch_reg] = cand_cnt_reg[ch_reg] + 1'b1;
                    meta_we               = 1'b1;
                    meta_wdata.cand       = 1'b1;
                end
                i_next = i_reg + 1'b1;
            end
            S_BPOP:
            begin
                if (build_more)
                begin
                    cand_head_next[ch_reg] = cand_head_reg[ch_reg] + 1'b1;
                    cand_cnt_next[ch_reg]  = cand_cnt_reg[ch_reg] - 1'b1;
                end
                else if (ch_last)
                begin
                    victim_ch_next = '0;
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            S_BKEY_RD:
            begin
                i_next     = cand_rdata;
                meta_raddr = {ch_reg, cand_rdata};
            end
            S_BKEY:
            begin
                key_next = meta_rdata.vcnt;
                j_next   = heap_cnt_reg[ch_reg];
            end
            S_BSH_RD:
            begin
                // Walk down the sorted list from its end.
                heap_raddr = {ch_reg, IDX_W'(j_reg - 1'b1)};
                if (j_reg == '0)
                begin
                    heap_we               = 1'b1;
                    heap_cnt_next[ch_reg] = heap_cnt_reg[ch_reg] + 1'b1;
                end
            end
            S_BSH_CHK:
            begin
                heap_we = 1'b1;
                if (heap_rdata.key > key_reg)
                begin
                    heap_wdata = heap_rdata;
                    j_next     = j_reg - 1'b1;
                end
                else
                begin
                    heap_cnt_next[ch_reg] = heap_cnt_reg[ch_reg] + 1'b1;
                end
            end
            S_PICK_SCAN:
            begin
                if (heap_avail)
                begin
                    heap_pos_next[ch_reg] = heap_pos_reg[ch_reg] + 1'b1;
                end
                else
                begin
                    ch_next = ch_inc(ch_reg);
                    n_next  = n_reg + 1'b1;
                end
            end
            S_PICK_RD:
            begin
                chosen_next    = {ch_reg, heap_rdata.idx};
                found_next     = 1'b1;
                victim_ch_next = ch_inc(ch_reg);
            end
            S_END_SCAN:
            begin
                if (heap_avail)
                begin
                    heap_pos_next[ch_reg] = heap_pos_reg[ch_reg] + 1'b1;
                end
                else if (!ch_last)
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            S_END_RD:
            begin
                i_next     = heap_rdata.idx;
                meta_raddr = {ch_reg, heap_rdata.idx};
            end
            S_END_WR:
            begin
                // Requeue the remaining entry; its candidate mark follows the push.
                meta_we         = 1'b1;
                meta_wdata.cand = cand_room;
                if (cand_room)
                begin
                    cand_we               = 1'b1;
                    cand_cnt_next[ch_reg] = cand_cnt_reg[ch_reg] + 1'b1;
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            init_reg       <= '0;
            low_thr_reg    <= LOW_THR_RESET;
            high_thr_reg   <= HIGH_THR_RESET;
            free_count_reg <= THR_W'(TOTAL_BLOCKS);
            alloc_ch_reg   <= '0;
            victim_ch_reg  <= '0;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                free_head_reg[c] <= '0;
                free_cnt_reg[c]  <= BPC_CNT;
                cand_head_reg[c] <= '0;
                cand_cnt_reg[c]  <= '0;
                heap_cnt_reg[c]  <= '0;
                heap_pos_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            alloc_ch_reg   <= alloc_ch_next;
            victim_ch_reg  <= victim_ch_next;
            free_head_reg  <= free_head_next;
            free_cnt_reg   <= free_cnt_next;
            cand_head_reg  <= cand_head_next;
            cand_cnt_reg   <= cand_cnt_next;
            heap_cnt_reg   <= heap_cnt_next;
            heap_pos_reg   <= heap_pos_next;
            if (state_reg == S_INIT)
            begin
                init_reg <= init_reg + 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LOW_THR:  low_thr_reg  <= cfg_data;
                    REG_HIGH_THR: high_thr_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            act_reg <= req.action;
            bid_reg <= req.block_id;
            vp_reg  <= req.valid_pages;
        end
        ch_reg      <= ch_next;
        n_reg       <= n_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        key_reg     <= key_next;
        found_reg   <= found_next;
        chosen_reg  <= chosen_next;
        if (out_load)
        begin
            out_chosen_reg <= ID_W'(chosen_reg);
            out_found_reg  <= found_reg;
            out_start_reg  <= free_count_reg <= low_thr_reg;
            out_stop_reg   <= free_count_reg >= high_thr_reg;
            out_free_reg   <= free_count_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.chosen_block = out_chosen_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.should_start = out_start_reg;
    assign rsp.should_stop  = out_stop_reg;
    assign rsp.free_total   = out_free_reg;

    // A response without a block reports block zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.found |-> rsp.chosen_block == '0)
        else $error("response without a block carries a nonzero block");

    // The free total never exceeds the number of blocks.
    assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= THR_W'(TOTAL_BLOCKS))
        else $error("free total above block count");

    // Picked entries never run past the end of a heap. The channel register
    // holds no value until the first request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(ch_reg) |-> heap_pos_reg[ch_reg] <= heap_cnt_reg[ch_reg])
        else $error("heap read position beyond heap size");

    // Allocation only happens from a FIFO that held a block.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ALLOC_WR |-> $past(state_reg) == S_ALLOC_RD
                                    && free_count_reg != '0)
        else $error("allocation with no free block");

    // Only allocate and pick report a found block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load && found_reg |-> act_reg == ACT_ALLOC || act_reg == ACT_PICK)
        else $error("found set for an action that yields no block");

endmodule
